// ===== sv/mqpp_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the MQTT packet field parser.
// No dependencies.
package mqpp_pkg;

  localparam int unsigned TopicLimit = 8;

  localparam logic [4:0] PH_HDR        = 5'd0;
  localparam logic [4:0] PH_LEN        = 5'd1;
  localparam logic [4:0] PH_SKIP       = 5'd2;
  localparam logic [4:0] PH_STR        = 5'd3;
  localparam logic [4:0] PH_PN_HI      = 5'd4;
  localparam logic [4:0] PH_PN_LO      = 5'd5;
  localparam logic [4:0] PH_LEVEL      = 5'd6;
  localparam logic [4:0] PH_CFLAGS     = 5'd7;
  localparam logic [4:0] PH_KA_HI      = 5'd8;
  localparam logic [4:0] PH_KA_LO      = 5'd9;
  localparam logic [4:0] PH_CID_HI     = 5'd10;
  localparam logic [4:0] PH_CID_LO     = 5'd11;
  localparam logic [4:0] PH_WT_HI      = 5'd12;
  localparam logic [4:0] PH_WT_LO      = 5'd13;
  localparam logic [4:0] PH_WM_HI      = 5'd14;
  localparam logic [4:0] PH_WM_LO      = 5'd15;
  localparam logic [4:0] PH_US_HI      = 5'd16;
  localparam logic [4:0] PH_US_LO      = 5'd17;
  localparam logic [4:0] PH_PW_HI      = 5'd18;
  localparam logic [4:0] PH_PW_LO      = 5'd19;
  localparam logic [4:0] PH_CA_FIRST   = 5'd20;
  localparam logic [4:0] PH_CA_CODE    = 5'd21;
  localparam logic [4:0] PH_TP_HI      = 5'd22;
  localparam logic [4:0] PH_TP_LO      = 5'd23;
  localparam logic [4:0] PH_PID_HI     = 5'd24;
  localparam logic [4:0] PH_PID_LO     = 5'd25;
  localparam logic [4:0] PH_PAYLOAD    = 5'd26;
  localparam logic [4:0] PH_REQ_QOS    = 5'd27;
  localparam logic [4:0] PH_SUBACK_RES = 5'd28;

  localparam logic [4:0] FC_HEADER  = 5'd0;
  localparam logic [4:0] FC_PN_LEN  = 5'd1;
  localparam logic [4:0] FC_LEVEL   = 5'd2;
  localparam logic [4:0] FC_CFLAGS  = 5'd3;
  localparam logic [4:0] FC_KA      = 5'd4;
  localparam logic [4:0] FC_CID_LEN = 5'd5;
  localparam logic [4:0] FC_WT_LEN  = 5'd6;
  localparam logic [4:0] FC_WM_LEN  = 5'd7;
  localparam logic [4:0] FC_US_LEN  = 5'd8;
  localparam logic [4:0] FC_PW_LEN  = 5'd9;
  localparam logic [4:0] FC_CA_CODE = 5'd10;
  localparam logic [4:0] FC_TP_LEN  = 5'd11;
  localparam logic [4:0] FC_PID     = 5'd12;
  localparam logic [4:0] FC_MSG_LEN = 5'd13;
  localparam logic [4:0] FC_REQ_QOS = 5'd14;
  localparam logic [4:0] FC_SUBACK  = 5'd15;
  localparam logic [4:0] FC_DATA    = 5'd16;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_LEN_OVF  = 2'd1;
  localparam logic [1:0] ERR_BAD_TYPE = 2'd2;

  localparam logic [3:0] T_CONNECT   = 4'd1;
  localparam logic [3:0] T_CONNACK   = 4'd2;
  localparam logic [3:0] T_PUBLISH   = 4'd3;
  localparam logic [3:0] T_SUBSCRIBE = 4'd8;
  localparam logic [3:0] T_SUBACK    = 4'd9;
  localparam logic [3:0] T_UNSUB     = 4'd10;
  localparam logic [3:0] T_UNSUBACK  = 4'd11;
  localparam logic [3:0] T_RESERVED  = 4'd15;

  typedef struct packed {
    logic [4:0]  code;
    logic [27:0] value;
    logic        ok;
    logic [1:0]  err;
  } mqpp_field_t;

  typedef struct packed {
    logic [3:0]  ptype;
    logic [3:0]  flags;
    logic        two;
    logic        pend;
    mqpp_field_t f0;
    mqpp_field_t f1;
  } mqpp_res_t;

endpackage

// ===== sv/mqpp_core.sv =====
`timescale 1ns / 1ps
// Parser state machine: one byte per cycle in while step is high, up to two fields out.
// Depends on mqpp_pkg.
module mqpp_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        data_byte,
  output mqpp_pkg::mqpp_res_t res,
  output logic              res_any
);
  import mqpp_pkg::*;

  logic [4:0]  phase_r, phase_nxt;
  logic [3:0]  type_r, type_nxt, flags_r, flags_nxt;
  logic [27:0] acc_r, acc_nxt, left_r, left_nxt;
  logic [2:0]  digs_r, digs_nxt;
  logic [15:0] str_r, str_nxt;
  logic [7:0]  held_r, held_nxt, cbits_r, cbits_nxt;
  logic [3:0]  tcnt_r, tcnt_nxt;

  logic [15:0] v;
  logic [1:0]  n;
  mqpp_field_t f [2];
  logic        pend;
  logic [27:0] left_dec;
  logic [27:0] acc_or;
  logic        topic_full;

  assign v          = {held_r, data_byte};
  assign topic_full = (tcnt_r >= 4'(TopicLimit));

  function automatic logic [4:0] after_user(input logic [7:0] cb);
    return cb[6] ? PH_PW_HI : PH_SKIP;
  endfunction
  function automatic logic [4:0] after_wm(input logic [7:0] cb);
    return cb[7] ? PH_US_HI : after_user(cb);
  endfunction
  function automatic logic [4:0] after_cid(input logic [7:0] cb);
    return cb[2] ? PH_WT_HI : after_wm(cb);
  endfunction

  always_comb begin
    logic [4:0]  tgt;
    logic        do_str;
    logic [3:0]  tc;
    tgt        = PH_SKIP;
    do_str     = 1'b0;
    tc         = tcnt_r;
    phase_nxt  = phase_r;
    type_nxt   = type_r;
    flags_nxt  = flags_r;
    acc_nxt    = acc_r;
    digs_nxt   = digs_r;
    left_nxt   = left_r;
    str_nxt    = str_r;
    held_nxt   = held_r;
    cbits_nxt  = cbits_r;
    tcnt_nxt   = tcnt_r;
    n          = 2'd0;
    pend       = 1'b0;
    f[0]       = '0;
    f[1]       = '0;
    acc_or     = '0;
    left_dec   = (left_r != 28'd0) ? left_r - 28'd1 : left_r;
    unique case (digs_r[1:0])
      2'd0: acc_or = {21'd0, data_byte[6:0]};
      2'd1: acc_or = {14'd0, data_byte[6:0], 7'd0};
      2'd2: acc_or = {7'd0, data_byte[6:0], 14'd0};
      default: acc_or = {data_byte[6:0], 21'd0};
    endcase
    if (phase_r == PH_HDR) begin
      type_nxt  = data_byte[7:4];
      flags_nxt = data_byte[3:0];
      acc_nxt   = '0;
      digs_nxt  = '0;
      tcnt_nxt  = '0;
      phase_nxt = PH_LEN;
    end else if (phase_r == PH_LEN) begin
      acc_nxt  = acc_r | acc_or;
      digs_nxt = digs_r + 3'd1;
      if (data_byte[7] && digs_nxt >= 3'd4) begin
        f[0] = '{FC_HEADER, acc_nxt, 1'b0, ERR_LEN_OVF};
        n = 2'd1; pend = 1'b1; phase_nxt = PH_HDR;
      end else if (!data_byte[7]) begin
        f[0].code  = FC_HEADER;
        f[0].value = acc_nxt;
        f[0].err   = (type_r == 4'd0 || type_r == T_RESERVED) ? ERR_BAD_TYPE : ERR_NONE;
        n = 2'd1;
        left_nxt = acc_nxt;
        if (acc_nxt == 28'd0) begin
          pend = 1'b1; phase_nxt = PH_HDR;
        end else if (f[0].err != ERR_NONE) begin
          phase_nxt = PH_SKIP;
        end else begin
          priority case (1'b1)
            type_r == T_CONNECT: phase_nxt = PH_PN_HI;
            type_r == T_CONNACK: phase_nxt = PH_CA_FIRST;
            type_r == T_PUBLISH: phase_nxt = PH_TP_HI;
            type_r >= 4'd4 && type_r <= T_UNSUBACK: phase_nxt = PH_PID_HI;
            default: phase_nxt = PH_SKIP;
          endcase
        end
      end
    end else begin
      left_nxt = left_dec;
      // tgt/do_str: start a string of length v, else enter tgt
      unique case (phase_r)
        PH_STR: begin
          f[0] = '{FC_DATA, {20'd0, data_byte}, 1'b0, ERR_NONE};
          n = 2'd1;
          str_nxt = (str_r != 16'd0) ? str_r - 16'd1 : str_r;
          if (str_nxt == 16'd0) begin
            tgt = held_r[4:0];
            if (tgt == PH_PAYLOAD) begin
              f[1] = '{FC_MSG_LEN, left_dec, 1'b0, ERR_NONE};
              n = 2'd2;
            end
            phase_nxt = tgt;
          end
        end
        PH_PN_HI, PH_KA_HI, PH_CID_HI, PH_WT_HI, PH_WM_HI, PH_US_HI, PH_PW_HI,
        PH_TP_HI, PH_PID_HI: begin
          held_nxt  = data_byte;
          phase_nxt = phase_r + 5'd1;
        end
        PH_PN_LO: begin
          f[0] = '{FC_PN_LEN, {12'd0, v}, 1'b0, ERR_NONE}; n = 2'd1;
          tgt = PH_LEVEL; do_str = 1'b1;
        end
        PH_LEVEL: begin
          f[0] = '{FC_LEVEL, {20'd0, data_byte}, 1'b0, ERR_NONE}; n = 2'd1;
          phase_nxt = PH_CFLAGS;
        end
        PH_CFLAGS: begin
          f[0] = '{FC_CFLAGS, {20'd0, data_byte}, 1'b0, ERR_NONE}; n = 2'd1;
          cbits_nxt = data_byte; phase_nxt = PH_KA_HI;
        end
        PH_KA_LO: begin
          f[0] = '{FC_KA, {12'd0, v}, 1'b0, ERR_NONE}; n = 2'd1;
          phase_nxt = PH_CID_HI;
        end
        PH_CID_LO: begin
          f[0] = '{FC_CID_LEN, {12'd0, v}, 1'b0, ERR_NONE}; n = 2'd1;
          tgt = after_cid(cbits_r); do_str = 1'b1;
        end
        PH_WT_LO: begin
          f[0] = '{FC_WT_LEN, {12'd0, v}, 1'b0, ERR_NONE}; n = 2'd1;
          tgt = PH_WM_HI; do_str = 1'b1;
        end
        PH_WM_LO: begin
          f[0] = '{FC_WM_LEN, {12'd0, v}, 1'b0, ERR_NONE}; n = 2'd1;
          tgt = after_wm(cbits_r); do_str = 1'b1;
        end
        PH_US_LO: begin
          f[0] = '{FC_US_LEN, {12'd0, v}, 1'b0, ERR_NONE}; n = 2'd1;
          tgt = after_user(cbits_r); do_str = 1'b1;
        end
        PH_PW_LO: begin
          f[0] = '{FC_PW_LEN, {12'd0, v}, 1'b0, ERR_NONE}; n = 2'd1;
          tgt = PH_SKIP; do_str = 1'b1;
        end
        PH_CA_FIRST: phase_nxt = PH_CA_CODE;
        PH_CA_CODE: begin
          f[0] = '{FC_CA_CODE, {20'd0, data_byte}, 1'b0, ERR_NONE}; n = 2'd1;
          phase_nxt = PH_SKIP;
        end
        PH_TP_LO: begin
          f[0] = '{FC_TP_LEN, {12'd0, v}, 1'b0, ERR_NONE}; n = 2'd1;
          if ((type_r == T_SUBSCRIBE || type_r == T_UNSUB) && tcnt_r < 4'd15)
            tc = tcnt_r + 4'd1;
          tcnt_nxt = tc;
          if (type_r == T_PUBLISH)
            tgt = (flags_r[2:1] != 2'd0) ? PH_PID_HI : PH_PAYLOAD;
          else if (type_r == T_SUBSCRIBE)
            tgt = PH_REQ_QOS;
          else
            tgt = (tc >= 4'(TopicLimit)) ? PH_SKIP : PH_TP_HI;
          do_str = 1'b1;
        end
        PH_PID_LO: begin
          f[0] = '{FC_PID, {12'd0, v}, 1'b0, ERR_NONE}; n = 2'd1;
          if (type_r == T_PUBLISH) begin
            f[1] = '{FC_MSG_LEN, left_dec, 1'b0, ERR_NONE}; n = 2'd2;
            phase_nxt = PH_PAYLOAD;
          end else if (type_r == T_SUBSCRIBE || type_r == T_UNSUB)
            phase_nxt = topic_full ? PH_SKIP : PH_TP_HI;
          else if (type_r == T_SUBACK)
            phase_nxt = PH_SUBACK_RES;
          else
            phase_nxt = PH_SKIP;
        end
        PH_PAYLOAD: begin
          f[0] = '{FC_DATA, {20'd0, data_byte}, 1'b0, ERR_NONE}; n = 2'd1;
        end
        PH_REQ_QOS: begin
          f[0] = '{FC_REQ_QOS, {20'd0, data_byte}, 1'b0, ERR_NONE}; n = 2'd1;
          phase_nxt = topic_full ? PH_SKIP : PH_TP_HI;
        end
        PH_SUBACK_RES: begin
          if (!topic_full) begin
            f[0] = '{FC_SUBACK, {26'd0, data_byte[1:0]}, data_byte[7:2] == 6'd0,
                     ERR_NONE};
            n = 2'd1;
            tcnt_nxt = tcnt_r + 4'd1;
          end
        end
        default: phase_nxt = PH_SKIP;
      endcase
      if (do_str) begin
        if (v == 16'd0) begin
          phase_nxt = tgt;
          if (tgt == PH_PAYLOAD) begin
            f[1] = '{FC_MSG_LEN, left_dec, 1'b0, ERR_NONE}; n = 2'd2;
          end
        end else begin
          str_nxt   = v;
          held_nxt  = {3'd0, tgt};
          phase_nxt = PH_STR;
        end
      end
      if (left_dec == 28'd0) begin
        pend = 1'b1;
        phase_nxt = PH_HDR;
        if (n == 2'd0) begin
          f[0] = '{FC_DATA, {20'd0, data_byte}, 1'b0, ERR_NONE}; n = 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR;
      type_r  <= '0; flags_r <= '0; acc_r <= '0; digs_r <= '0;
      left_r  <= '0; str_r <= '0; held_r <= '0; cbits_r <= '0; tcnt_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      type_r  <= type_nxt;  flags_r <= flags_nxt; acc_r <= acc_nxt;
      digs_r  <= digs_nxt;  left_r <= left_nxt;   str_r <= str_nxt;
      held_r  <= held_nxt;  cbits_r <= cbits_nxt; tcnt_r <= tcnt_nxt;
    end
  end

  assign res_any   = (n != 2'd0);
  assign res.ptype = type_nxt;
  assign res.flags = flags_nxt;
  assign res.two   = (n == 2'd2);
  assign res.pend  = pend;
  assign res.f0    = f[0];
  assign res.f1    = f[1];

endmodule

// ===== sv/mqtt_packet_field_parser.sv =====
`timescale 1ns / 1ps
// MQTT 3.1 packet field parser. Takes one stream byte per cycle when the
// result side keeps up; a byte that yields two fields (publish message length
// with its id or topic end) holds the output until both fields are taken, and
// meanwhile the next byte is already registered. Depends on mqpp_pkg and mqpp_core.
module mqtt_packet_field_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_packet_type,
  output logic [3:0]  out_header_flags,
  output logic [4:0]  out_field_code,
  output logic [27:0] out_field_value,
  output logic        out_granted_ok,
  output logic [1:0]  out_error_code,
  output logic        out_packet_end,
  output logic        out_run_last
);
  import mqpp_pkg::*;

  logic       ib_valid_r;
  logic [7:0] ib_byte_r;
  mqpp_res_t  res, ob_r;
  logic       res_any;
  logic       ob_valid_r, ob_sec_r;
  logic       ob_free, step;

  // output word done when free or its last field is taken
  assign ob_free  = !ob_valid_r || (out_ready && (!ob_r.two || ob_sec_r));
  assign step     = ib_valid_r && ob_free;
  assign in_ready = !ib_valid_r || step;

  mqpp_core u_core (
    .clk(clk), .rst_n(rst_n), .step(step), .data_byte(ib_byte_r),
    .res(res), .res_any(res_any)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ib_valid_r <= 1'b0;
    end else if (in_ready) begin
      ib_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) ib_byte_r <= in_data_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_valid_r <= 1'b0;
      ob_sec_r   <= 1'b0;
    end else if (ob_free) begin
      ob_valid_r <= step && res_any;
      ob_sec_r   <= 1'b0;
    end else if (out_ready) begin
      ob_sec_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ob_free && step) ob_r <= res;
  end

  assign out_valid        = ob_valid_r;
  assign out_packet_type  = ob_r.ptype;
  assign out_header_flags = ob_r.flags;
  assign out_field_code   = ob_sec_r ? ob_r.f1.code  : ob_r.f0.code;
  assign out_field_value  = ob_sec_r ? ob_r.f1.value : ob_r.f0.value;
  assign out_granted_ok   = ob_sec_r ? ob_r.f1.ok    : ob_r.f0.ok;
  assign out_error_code   = ob_sec_r ? ob_r.f1.err   : ob_r.f0.err;
  assign out_run_last     = !ob_r.two || ob_sec_r;
  assign out_packet_end   = out_run_last && ob_r.pend;

  a_sec_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
    ob_sec_r |-> (ob_valid_r && ob_r.two)) else $error("second field without pair");
  a_err_on_header: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error_code != ERR_NONE) |-> (out_field_code == FC_HEADER))
    else $error("error on non-header field");
  a_ok_suback: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_granted_ok) |-> (out_field_code == FC_SUBACK))
    else $error("granted flag outside suback");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_field_value)))
    else $error("output word dropped");

endmodule
